@@ sv/x86_16_alu_branch_execute_unit_assert.svh @@
// Assertion macros for the x86 16-bit execute unit.
// Used by xabe_back under sv; no dependencies.
`ifndef X86_16_ALU_BRANCH_EXECUTE_UNIT_ASSERT_SVH
`define X86_16_ALU_BRANCH_EXECUTE_UNIT_ASSERT_SVH
`ifndef SYNTH
`define XAB_ASSERT(label, clk_i, rst_ni, prop) \
    label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
        else $error("assertion failed");
`define XAB_ASSERT_NR(label, clk_i, prop) \
    label: assert property (@(posedge clk_i) prop) else $error("assertion failed");
`else
`define XAB_ASSERT(label, clk_i, rst_ni, prop)
`define XAB_ASSERT_NR(label, clk_i, prop)
`endif
`endif

@@ sv/xabe_pkg.sv @@
// Package for the x86 16-bit execute unit: opcodes, kinds, flag bits, item types.
// No dependencies.
`timescale 1ns / 1ps
package xabe_pkg;
    localparam int ADDR_BITS = 20;

    typedef enum logic [4:0] {
        OP_MOV = 5'd0, OP_ADD = 5'd1, OP_SUB = 5'd2, OP_CMP = 5'd3,
        OP_JE = 5'd4, OP_JL = 5'd5, OP_JLE = 5'd6, OP_JB = 5'd7,
        OP_JBE = 5'd8, OP_JP = 5'd9, OP_JO = 5'd10, OP_JS = 5'd11,
        OP_JNE = 5'd12, OP_JNL = 5'd13, OP_JNLE = 5'd14, OP_JNB = 5'd15,
        OP_JNBE = 5'd16, OP_JNP = 5'd17, OP_JNO = 5'd18, OP_JNS = 5'd19,
        OP_LOOP = 5'd20, OP_LOOPE = 5'd21, OP_LOOPNE = 5'd22, OP_JCXZ = 5'd23
    } op_t;

    localparam logic [1:0] DK_REG = 2'd0;
    localparam logic [1:0] DK_MEM = 2'd1;
    localparam logic [1:0] SK_REG = 2'd0;
    localparam logic [1:0] SK_MEM = 2'd2;

    localparam int F_CF = 0;
    localparam int F_PF = 2;
    localparam int F_AF = 4;
    localparam int F_ZF = 6;
    localparam int F_SF = 7;
    localparam int F_OF = 11;
    localparam logic [2:0] REG_CX = 3'd1;

    typedef enum logic [1:0] {
        CL_NONE = 2'd0, CL_DATA = 2'd1, CL_BRANCH = 2'd2
    } class_t;

    typedef struct packed {
        class_t                 cls;
        logic [4:0]             op;
        logic                   wide;
        logic                   dest_mem;
        logic [2:0]             dest_reg;
        logic [1:0]             src_kind;
        logic [2:0]             src_reg;
        logic [15:0]            immediate;
        logic [ADDR_BITS-1:0]   mem_addr;
        logic [15:0]            mem_data;
        logic [2:0]             ip_advance;
        logic [7:0]             jump_disp;
    } uop_t;

    localparam int QDEPTH = 2;
endpackage

@@ sv/xabe_front.sv @@
// Front end: accepts items, classifies them and queues them for the back end.
// Depends on xabe_pkg.
`timescale 1ns / 1ps
module xabe_front
    import xabe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [4:0]  op,
    input  logic        wide,
    input  logic [1:0]  dest_kind,
    input  logic [2:0]  dest_reg,
    input  logic [1:0]  src_kind,
    input  logic [2:0]  src_reg,
    input  logic [15:0] immediate,
    input  logic [19:0] mem_addr,
    input  logic [15:0] mem_data,
    input  logic [2:0]  ip_advance,
    input  logic signed [7:0] jump_disp,
    output logic        uop_valid,
    output uop_t        uop,
    input  logic        uop_take
);
    uop_t        q_reg [QDEPTH];
    logic [1:0]  cnt_reg, cnt_next;
    logic        rd_reg, rd_next, wr_reg, wr_next;
    logic        do_push, do_pop;
    uop_t        in_uop;

    always_comb
    begin
        if (op <= OP_CMP && dest_kind <= DK_MEM)
            in_uop.cls = CL_DATA;
        else if (op >= OP_JE && op <= OP_JCXZ)
            in_uop.cls = CL_BRANCH;
        else
            in_uop.cls = CL_NONE;
        in_uop.op         = op;
        in_uop.wide       = wide;
        in_uop.dest_mem   = (dest_kind == DK_MEM);
        in_uop.dest_reg   = dest_reg;
        in_uop.src_kind   = src_kind;
        in_uop.src_reg    = src_reg;
        in_uop.immediate  = immediate;
        in_uop.mem_addr   = mem_addr[ADDR_BITS-1:0];
        in_uop.mem_data   = mem_data;
        in_uop.ip_advance = ip_advance;
        in_uop.jump_disp  = jump_disp;
    end

    assign full      = (cnt_reg == 2'(QDEPTH));
    assign uop_valid = (cnt_reg != 2'd0);
    assign uop       = q_reg[rd_reg];
    assign do_push   = push && !full;
    assign do_pop    = uop_valid && uop_take;

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        rd_next  = rd_reg ^ do_pop;
        wr_next  = wr_reg ^ do_push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_reg] <= in_uop;
    end
endmodule

@@ sv/xabe_back.sv @@
// Back end: register file, IP, flags, ALU, branch logic and result register.
// Depends on xabe_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "x86_16_alu_branch_execute_unit_assert.svh"
module xabe_back
    import xabe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        uop_valid,
    input  uop_t        uop,
    output logic        uop_take,
    output logic        empty,
    input  logic        pop,
    output logic        mem_write,
    output logic [19:0] mem_write_addr,
    output logic [15:0] mem_write_data,
    output logic [15:0] new_ip,
    output logic [11:0] flags_word,
    output logic        branch_taken,
    output logic [15:0] result_value
);
    logic [15:0] rf_reg [8];
    logic [15:0] ip_reg, ip_next;
    logic [11:0] fl_reg, fl_next;
    logic        ov_reg;
    logic        mw_reg;
    logic [19:0] wa_reg;
    logic [15:0] wd_reg, res_reg, nip_reg;
    logic [11:0] fw_reg;
    logic        bt_reg;

    logic [15:0] m, d, s, res, rd_d, rd_s, sum, cx_dec;
    logic [16:0] full17;
    logic        sbit, cf, ovf, taken, wr_rf, wr_cx, fire, is_data;
    logic [15:0] disp16;

    function automatic logic [15:0] rdreg(input logic [15:0] rf [8],
                                          input logic [2:0] c, input logic w);
        logic [15:0] v;
        v = rf[{1'b0, c[1:0]}];
        if (w)
            return rf[c];
        else if (c[2])
            return {8'h00, v[15:8]};
        else
            return {8'h00, v[7:0]};
    endfunction

    assign empty    = !ov_reg;
    assign uop_take = !ov_reg || pop;
    assign fire     = uop_valid && uop_take;
    assign is_data  = (uop.cls == CL_DATA);

    always_comb
    begin
        m      = uop.wide ? 16'hFFFF : 16'h00FF;
        rd_d   = rdreg(rf_reg, uop.dest_reg, uop.wide);
        rd_s   = rdreg(rf_reg, uop.src_reg, uop.wide);
        d      = uop.dest_mem ? (uop.mem_data & m) : rd_d;
        case (uop.src_kind)
            SK_REG:  s = rd_s;
            SK_MEM:  s = uop.mem_data & m;
            default: s = uop.immediate & m;
        endcase
        if (uop.op == OP_ADD)
            full17 = {1'b0, d} + {1'b0, s};
        else
            full17 = {1'b0, d} - {1'b0, s};
        sum  = full17[15:0] & m;
        sbit = uop.wide ? sum[15] : sum[7];
        cf   = uop.wide ? full17[16] : full17[8];
        if (uop.op == OP_ADD)
            ovf = uop.wide ? (~(d[15] ^ s[15]) & (d[15] ^ sum[15]))
                           : (~(d[7] ^ s[7]) & (d[7] ^ sum[7]));
        else
            ovf = uop.wide ? ((d[15] ^ s[15]) & (d[15] ^ sum[15]))
                           : ((d[7] ^ s[7]) & (d[7] ^ sum[7]));
        res     = 16'h0000;
        fl_next = fl_reg;
        wr_rf   = 1'b0;
        if (is_data)
        begin
            if (uop.op == OP_MOV)
                res = s;
            else
            begin
                res = sum;
                fl_next = fl_reg;
                fl_next[F_CF] = cf;
                fl_next[F_PF] = ~(^sum[7:0]);
                fl_next[F_AF] = d[4] ^ s[4] ^ sum[4];
                fl_next[F_ZF] = (sum == 16'h0000);
                fl_next[F_SF] = sbit;
                fl_next[F_OF] = ovf;
            end
            wr_rf = (uop.op != OP_CMP) && !uop.dest_mem;
        end
        cx_dec = rf_reg[REG_CX] - 16'd1;
        wr_cx  = 1'b0;
        taken  = 1'b0;
        if (uop.cls == CL_BRANCH)
        begin
            case (uop.op)
                OP_JE:     taken = fl_reg[F_ZF];
                OP_JL:     taken = fl_reg[F_SF] ^ fl_reg[F_OF];
                OP_JLE:    taken = fl_reg[F_ZF] | (fl_reg[F_SF] ^ fl_reg[F_OF]);
                OP_JB:     taken = fl_reg[F_CF];
                OP_JBE:    taken = fl_reg[F_CF] | fl_reg[F_ZF];
                OP_JP:     taken = fl_reg[F_PF];
                OP_JO:     taken = fl_reg[F_OF];
                OP_JS:     taken = fl_reg[F_SF];
                OP_JNE:    taken = !fl_reg[F_ZF];
                OP_JNL:    taken = !(fl_reg[F_SF] ^ fl_reg[F_OF]);
                OP_JNLE:   taken = !fl_reg[F_ZF] && !(fl_reg[F_SF] ^ fl_reg[F_OF]);
                OP_JNB:    taken = !fl_reg[F_CF];
                OP_JNBE:   taken = !fl_reg[F_CF] && !fl_reg[F_ZF];
                OP_JNP:    taken = !fl_reg[F_PF];
                OP_JNO:    taken = !fl_reg[F_OF];
                OP_JNS:    taken = !fl_reg[F_SF];
                OP_LOOP:
                begin
                    wr_cx = 1'b1;
                    taken = (cx_dec != 16'h0000);
                end
                OP_LOOPE:
                begin
                    wr_cx = 1'b1;
                    taken = (cx_dec != 16'h0000) && fl_reg[F_ZF];
                end
                OP_LOOPNE:
                begin
                    wr_cx = 1'b1;
                    taken = (cx_dec != 16'h0000) && !fl_reg[F_ZF];
                end
                default:   taken = (rf_reg[REG_CX] == 16'h0000);
            endcase
        end
        disp16  = {{8{uop.jump_disp[7]}}, uop.jump_disp};
        ip_next = ip_reg + {13'd0, uop.ip_advance} + (taken ? disp16 : 16'h0000);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                rf_reg[i] <= '0;
            ip_reg <= '0;
            fl_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                ip_reg <= ip_next;
                fl_reg <= fl_next;
                if (wr_cx)
                    rf_reg[REG_CX] <= cx_dec;
                if (wr_rf)
                begin
                    if (uop.wide)
                        rf_reg[uop.dest_reg] <= res;
                    else if (uop.dest_reg[2])
                        rf_reg[{1'b0, uop.dest_reg[1:0]}][15:8] <= res[7:0];
                    else
                        rf_reg[{1'b0, uop.dest_reg[1:0]}][7:0] <= res[7:0];
                end
            end
            if (fire)
                ov_reg <= 1'b1;
            else if (pop)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            mw_reg  <= is_data && uop.dest_mem && (uop.op != OP_CMP);
            wa_reg  <= (is_data && uop.dest_mem && (uop.op != OP_CMP))
                       ? 20'(uop.mem_addr) : 20'd0;
            wd_reg  <= (is_data && uop.dest_mem && (uop.op != OP_CMP)) ? res : 16'h0000;
            res_reg <= res;
            nip_reg <= ip_next;
            fw_reg  <= fl_next;
            bt_reg  <= taken;
        end
    end

    assign mem_write      = mw_reg;
    assign mem_write_addr = wa_reg;
    assign mem_write_data = wd_reg;
    assign new_ip         = nip_reg;
    assign flags_word     = fw_reg;
    assign branch_taken   = bt_reg;
    assign result_value   = res_reg;

    `XAB_ASSERT(a_take_when_free, clk, rst_n, (!ov_reg && uop_valid) |=> !empty)
    `XAB_ASSERT(a_hold_on_stall, clk, rst_n, (ov_reg && !pop) |=> (!empty && $stable(nip_reg)))
    `XAB_ASSERT(a_ip_tracks, clk, rst_n, fire |=> (ip_reg == new_ip))
    `XAB_ASSERT(a_flags_track, clk, rst_n, fire |=> (fl_reg == flags_word))
endmodule

@@ sv/x86_16_alu_branch_execute_unit.sv @@
// Top level of the x86 16-bit execute unit: front end, queue and back end.
// Depends on xabe_pkg, xabe_front and xabe_back.
// One instruction per cycle sustained while pop keeps the result register
// draining: each item passes from push through the two-entry front queue to
// the execute stage, whose register file, IP and flags update in the same
// cycle the result register loads, and empty goes low as that register loads.
`timescale 1ns / 1ps
module x86_16_alu_branch_execute_unit
    import xabe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [4:0]  op,
    input  logic        wide,
    input  logic [1:0]  dest_kind,
    input  logic [2:0]  dest_reg,
    input  logic [1:0]  src_kind,
    input  logic [2:0]  src_reg,
    input  logic [15:0] immediate,
    input  logic [19:0] mem_addr,
    input  logic [15:0] mem_data,
    input  logic [2:0]  ip_advance,
    input  logic signed [7:0] jump_disp,
    output logic        empty,
    input  logic        pop,
    output logic        mem_write,
    output logic [19:0] mem_write_addr,
    output logic [15:0] mem_write_data,
    output logic [15:0] new_ip,
    output logic [11:0] flags_word,
    output logic        branch_taken,
    output logic [15:0] result_value
);
    logic uop_valid, uop_take;
    uop_t uop;

    xabe_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .op(op), .wide(wide), .dest_kind(dest_kind), .dest_reg(dest_reg),
        .src_kind(src_kind), .src_reg(src_reg), .immediate(immediate),
        .mem_addr(mem_addr), .mem_data(mem_data), .ip_advance(ip_advance),
        .jump_disp(jump_disp), .uop_valid(uop_valid), .uop(uop), .uop_take(uop_take)
    );

    xabe_back u_back (
        .clk(clk), .rst_n(rst_n), .uop_valid(uop_valid), .uop(uop),
        .uop_take(uop_take), .empty(empty), .pop(pop),
        .mem_write(mem_write), .mem_write_addr(mem_write_addr),
        .mem_write_data(mem_write_data), .new_ip(new_ip), .flags_word(flags_word),
        .branch_taken(branch_taken), .result_value(result_value)
    );
endmodule

@@ verif/x86_16_alu_branch_execute_unit_test.sv @@
// Testbench for x86_16_alu_branch_execute_unit: directed and random 8086 items,
// checked against an in-bench model of registers, IP and flags. Uses xabe_pkg.
`timescale 1ns / 1ps
module x86_16_alu_branch_execute_unit_test;
    import xabe_pkg::*;

    typedef struct {
        logic [4:0]  op;
        logic        wide;
        logic [1:0]  dest_kind;
        logic [2:0]  dest_reg;
        logic [1:0]  src_kind;
        logic [2:0]  src_reg;
        logic [15:0] immediate;
        logic [19:0] mem_addr;
        logic [15:0] mem_data;
        logic [2:0]  ip_advance;
        logic [7:0]  jump_disp;
    } instr_t;

    typedef struct {
        logic        mem_write;
        logic [19:0] mem_write_addr;
        logic [15:0] mem_write_data;
        logic [15:0] new_ip;
        logic [11:0] flags_word;
        logic        branch_taken;
        logic [15:0] result_value;
    } outcome_t;

    localparam logic [1:0] DK_JUMP = 2'd2;
    localparam logic [1:0] SK_IMM = 2'd1;
    localparam int LIMIT = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty;
    logic [4:0] op = '0;
    logic wide = 1'b0;
    logic [1:0] dest_kind = '0;
    logic [2:0] dest_reg = '0;
    logic [1:0] src_kind = '0;
    logic [2:0] src_reg = '0;
    logic [15:0] immediate = '0;
    logic [19:0] mem_addr = '0;
    logic [15:0] mem_data = '0;
    logic [2:0] ip_advance = 3'd1;
    logic signed [7:0] jump_disp = '0;
    logic mem_write, branch_taken;
    logic [19:0] mem_write_addr;
    logic [15:0] mem_write_data, new_ip, result_value;
    logic [11:0] flags_word;

    x86_16_alu_branch_execute_unit dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic [15:0] regs [8];
    logic [15:0] ip_model;
    logic [11:0] flag_model;
    instr_t pending [$];
    outcome_t expected [$];
    int errors = 0;
    int cycles = 0;
    bit stim_done = 1'b0;
    bit hold = 1'b0;
    int burst = 0;
    int gap = 0;

    function automatic logic [15:0] reg_get(logic [2:0] code, logic w);
        if (w)
            return regs[code];
        return code[2] ? {8'h00, regs[{1'b0, code[1:0]}][15:8]}
                       : {8'h00, regs[{1'b0, code[1:0]}][7:0]};
    endfunction

    function automatic void reg_put(logic [2:0] code, logic w, logic [15:0] v);
        if (w)
            regs[code] = v;
        else if (code[2])
            regs[{1'b0, code[1:0]}][15:8] = v[7:0];
        else
            regs[{1'b0, code[1:0]}][7:0] = v[7:0];
    endfunction

    function automatic outcome_t execute(instr_t t);
        outcome_t r;
        logic [15:0] m, sg, d, s, res;
        logic [16:0] sum;
        logic cf, pf, zf, sf, of, tk;
        m = t.wide ? 16'hFFFF : 16'h00FF;
        sg = t.wide ? 16'h8000 : 16'h0080;
        r = '{default: '0};
        res = '0;
        tk = 1'b0;
        ip_model = ip_model + 16'(t.ip_advance);
        if (t.op <= OP_CMP && t.dest_kind <= DK_MEM) begin
            d = (t.dest_kind == DK_REG) ? reg_get(t.dest_reg, t.wide) : (t.mem_data & m);
            if (t.src_kind == SK_REG)
                s = reg_get(t.src_reg, t.wide);
            else if (t.src_kind == SK_MEM)
                s = t.mem_data & m;
            else
                s = t.immediate & m;
            if (t.op == OP_MOV)
                res = s;
            else begin
                if (t.op == OP_ADD) begin
                    sum = {1'b0, d} + {1'b0, s};
                    res = sum[15:0] & m;
                    cf = sum > {1'b0, m};
                    of = |(~(d ^ s) & (d ^ res) & sg);
                end else begin
                    res = (d - s) & m;
                    cf = d < s;
                    of = |((d ^ s) & (d ^ res) & sg);
                end
                flag_model[F_CF] = cf;
                flag_model[F_PF] = ~^res[7:0];
                flag_model[F_AF] = d[4] ^ s[4] ^ res[4];
                flag_model[F_ZF] = res == 16'd0;
                flag_model[F_SF] = |(res & sg);
                flag_model[F_OF] = of;
            end
            if (t.op != OP_CMP) begin
                if (t.dest_kind == DK_REG)
                    reg_put(t.dest_reg, t.wide, res);
                else begin
                    r.mem_write = 1'b1;
                    r.mem_write_addr = t.mem_addr;
                    r.mem_write_data = res;
                end
            end
        end else if (t.op >= OP_JE && t.op <= OP_JCXZ) begin
            cf = flag_model[F_CF];
            pf = flag_model[F_PF];
            zf = flag_model[F_ZF];
            sf = flag_model[F_SF];
            of = flag_model[F_OF];
            case (t.op)
                OP_JE: tk = zf;
                OP_JL: tk = sf != of;
                OP_JLE: tk = zf || sf != of;
                OP_JB: tk = cf;
                OP_JBE: tk = cf || zf;
                OP_JP: tk = pf;
                OP_JO: tk = of;
                OP_JS: tk = sf;
                OP_JNE: tk = !zf;
                OP_JNL: tk = sf == of;
                OP_JNLE: tk = !zf && sf == of;
                OP_JNB: tk = !cf;
                OP_JNBE: tk = !cf && !zf;
                OP_JNP: tk = !pf;
                OP_JNO: tk = !of;
                OP_JNS: tk = !sf;
                OP_JCXZ: tk = regs[REG_CX] == 16'd0;
                default:
                begin
                    regs[REG_CX] = regs[REG_CX] - 16'd1;
                    tk = regs[REG_CX] != 16'd0;
                    if (t.op == OP_LOOPE)
                        tk = tk && zf;
                    else if (t.op == OP_LOOPNE)
                        tk = tk && !zf;
                end
            endcase
            if (tk)
                ip_model = ip_model + {{8{t.jump_disp[7]}}, t.jump_disp};
        end
        r.new_ip = ip_model;
        r.flags_word = flag_model;
        r.branch_taken = tk;
        r.result_value = res;
        return r;
    endfunction

    function automatic instr_t random_instr();
        instr_t t;
        int sel;
        sel = $urandom_range(0, 99);
        t.op = (sel < 55) ? 5'($urandom_range(0, 3))
             : (sel < 95) ? 5'($urandom_range(4, 23)) : 5'($urandom_range(24, 31));
        t.wide = 1'($urandom_range(0, 1));
        t.dest_kind = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(2, 3))
                    : 2'($urandom_range(0, 1));
        t.dest_reg = 3'($urandom_range(0, 7));
        t.src_kind = 2'($urandom_range(0, 3));
        t.src_reg = 3'($urandom_range(0, 7));
        t.immediate = 16'($urandom);
        if ($urandom_range(0, 4) == 0)
            t.immediate = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        t.mem_addr = 20'($urandom);
        t.mem_data = 16'($urandom);
        t.ip_advance = 3'($urandom_range(0, 7));
        t.jump_disp = 8'($urandom);
        return t;
    endfunction

    function automatic instr_t make(logic [4:0] o, logic w, logic [1:0] dk, logic [2:0] dr,
                                    logic [1:0] sk, logic [2:0] sr, logic [15:0] im,
                                    logic [15:0] md);
        instr_t t;
        t.op = o; t.wide = w; t.dest_kind = dk; t.dest_reg = dr;
        t.src_kind = sk; t.src_reg = sr; t.immediate = im;
        t.mem_addr = 20'hFFFFF; t.mem_data = md; t.ip_advance = 3'd6; t.jump_disp = 8'h80;
        return t;
    endfunction

    initial
    begin
        instr_t t;
        pending.push_back(make(OP_MOV, 1'b1, DK_REG, 3'd0, SK_IMM, 3'd0, 16'hFFFF, 16'h0));
        pending.push_back(make(OP_ADD, 1'b1, DK_REG, 3'd0, SK_IMM, 3'd0, 16'h0001, 16'h0));
        pending.push_back(make(OP_JE, 1'b1, DK_JUMP, 3'd0, SK_IMM, 3'd0, 16'h0, 16'h0));
        pending.push_back(make(OP_JB, 1'b1, DK_JUMP, 3'd0, SK_IMM, 3'd0, 16'h0, 16'h0));
        pending.push_back(make(OP_MOV, 1'b0, DK_REG, 3'd4, SK_IMM, 3'd0, 16'h007F, 16'h0));
        pending.push_back(make(OP_ADD, 1'b0, DK_REG, 3'd4, SK_IMM, 3'd0, 16'h0001, 16'h0));
        pending.push_back(make(OP_JO, 1'b0, DK_JUMP, 3'd0, SK_IMM, 3'd0, 16'h0, 16'h0));
        pending.push_back(make(OP_JS, 1'b0, DK_JUMP, 3'd0, SK_IMM, 3'd0, 16'h0, 16'h0));
        pending.push_back(make(OP_CMP, 1'b0, DK_REG, 3'd4, SK_MEM, 3'd0, 16'h0, 16'hFFFF));
        pending.push_back(make(OP_SUB, 1'b1, DK_MEM, 3'd0, SK_REG, 3'd4, 16'h0, 16'h0000));
        pending.push_back(make(OP_ADD, 1'b0, DK_MEM, 3'd0, SK_IMM, 3'd0, 16'h0FFF, 16'hFF01));
        pending.push_back(make(OP_MOV, 1'b1, DK_JUMP, 3'd0, SK_IMM, 3'd0, 16'h1234, 16'h0));
        pending.push_back(make(OP_MOV, 1'b1, DK_REG, 3'd1, SK_IMM, 3'd0, 16'h0002, 16'h0));
        pending.push_back(make(OP_LOOP, 1'b1, DK_JUMP, 3'd0, SK_IMM, 3'd0, 16'h0, 16'h0));
        pending.push_back(make(OP_LOOPE, 1'b1, DK_JUMP, 3'd0, SK_IMM, 3'd0, 16'h0, 16'h0));
        pending.push_back(make(OP_JCXZ, 1'b1, DK_JUMP, 3'd0, SK_IMM, 3'd0, 16'h0, 16'h0));
        pending.push_back(make(OP_LOOPNE, 1'b1, DK_JUMP, 3'd0, SK_IMM, 3'd0, 16'h0, 16'h0));
        pending.push_back(make(5'd31, 1'b1, DK_REG, 3'd7, 2'd3, 3'd7, 16'h0, 16'h0));
        pending.push_back(make(OP_ADD, 1'b1, DK_REG, 3'd7, 2'd3, 3'd0, 16'h8000, 16'h0));
        for (int i = 0; i < 950; i++) begin
            t = random_instr();
            if (i == 475)
            begin
                wait (pending.size() == 0);
                hold = 1'b1;
                wait (expected.size() == 0);
                hold = 1'b0;
            end
            pending.push_back(t);
        end
        stim_done = 1'b1;
    end

    // Present the queue head; an accepted head is predicted and dropped at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        instr_t h;
        instr_t a;
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
            begin
                a = pending.pop_front();
                expected.push_back(execute(a));
            end
            if (gap > 0)
                gap <= gap - 1;
            if (burst == 0 && gap == 0)
            begin
                burst <= $urandom_range(1, 40);
                gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            end
            else if (burst > 0)
                burst <= burst - 1;
            if (pending.size() > 0 && !hold && gap == 0)
            begin
                h = pending[0];
                push <= 1'b1;
                op <= h.op; wide <= h.wide; dest_kind <= h.dest_kind;
                dest_reg <= h.dest_reg; src_kind <= h.src_kind; src_reg <= h.src_reg;
                immediate <= h.immediate; mem_addr <= h.mem_addr; mem_data <= h.mem_data;
                ip_advance <= h.ip_advance; jump_disp <= h.jump_disp;
            end
            else
                push <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        outcome_t e;
        cycles <= cycles + 1;
        if (rst_n && pop && !empty)
        begin
            if (expected.size() == 0)
            begin
                $error("result with no item pending");
                errors++;
            end
            else
            begin
                e = expected.pop_front();
                if (mem_write !== e.mem_write)
                    begin $error("mem_write exp %h got %h", e.mem_write, mem_write); errors++; end
                if (mem_write_addr !== e.mem_write_addr)
                    begin $error("mem_write_addr exp %h got %h", e.mem_write_addr,
                                 mem_write_addr); errors++; end
                if (mem_write_data !== e.mem_write_data)
                    begin $error("mem_write_data exp %h got %h", e.mem_write_data,
                                 mem_write_data); errors++; end
                if (new_ip !== e.new_ip)
                    begin $error("new_ip exp %h got %h", e.new_ip, new_ip); errors++; end
                if (flags_word !== e.flags_word)
                    begin $error("flags_word exp %h got %h", e.flags_word, flags_word);
                          errors++; end
                if (branch_taken !== e.branch_taken)
                    begin $error("branch_taken exp %h got %h", e.branch_taken, branch_taken);
                          errors++; end
                if (result_value !== e.result_value)
                    begin $error("result_value exp %h got %h", e.result_value, result_value);
                          errors++; end
            end
        end
        pop <= rst_n && (cycles % 23 > 15 ? 1'b0 : $urandom_range(0, 3) != 0);
    end

    initial
    begin
        for (int i = 0; i < 8; i++)
            regs[i] = '0;
        ip_model = '0;
        flag_model = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        wait (stim_done && pending.size() == 0 && expected.size() == 0);
        repeat (10) @(posedge clk);
        if (errors == 0 && expected.size() == 0)
            $display("x86_16_alu_branch_execute_unit_test passed");
        else
            $display("x86_16_alu_branch_execute_unit_test failed");
        $finish;
    end

    initial
    begin
        wait (cycles >= LIMIT);
        $display("x86_16_alu_branch_execute_unit_test failed");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+sv
sv/xabe_pkg.sv
sv/xabe_front.sv
sv/xabe_back.sv
sv/x86_16_alu_branch_execute_unit.sv
verif/x86_16_alu_branch_execute_unit_test.sv
